FILE: design/brb_pkg.sv
// shared constants for the byte ring buffer: field widths, operation codes
// and parameter defaults; no dependencies
package brb_pkg;

   localparam int LEN_W   = 13;   // length, counts and levels on the ports
   localparam int DATA_W  = 64;   // eight bytes of payload
   localparam int OFF_W   = 12;   // span offset
   localparam int KIND_W  = 3;
   localparam int IDX_W   = 3;    // byte lane inside the 64-bit payload
   localparam int NUM_W   = 4;    // byte count of one burst, 0..8

   localparam int DEPTH_DEFAULT = 4096;
   localparam int BURST_DEFAULT = 8;

   localparam logic [KIND_W-1:0] KIND_WRITE   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_READ    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_PEEK    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_CONSUME = 3'd3;
   localparam logic [KIND_W-1:0] KIND_SPAN    = 3'd4;
   localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd5;

endpackage

FILE: design/byte_ring_buffer.sv
// Byte ring buffer with a single byte-wide storage port. Write, read and peek move
// one byte per clock through that port: a write stays in ST_WR until its last byte
// is stored, a read or peek stays in ST_RD and then takes its last byte from the
// registered store read in ST_RDL, with the result strobed on rsp_valid in the first
// cycle that busy is low again. Consume, span query, clear, unused kinds and
// bursts of zero bytes finish at once: their result shows in the cycle after the
// request and a new request can be taken in that same cycle. Every result is on
// the rsp_ ports for one cycle only and must be captured then. A capacity write
// is taken whenever busy is low and no request is offered on start, and it
// empties the buffer. No clearing pass runs after reset; slots are only ever
// read after they were written.
// depends on brb_pkg
module byte_ring_buffer #(
   parameter int DEPTH       = brb_pkg::DEPTH_DEFAULT,
   parameter int BURST_BYTES = brb_pkg::BURST_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [brb_pkg::KIND_W-1:0]    req_kind,
   input  logic [brb_pkg::LEN_W-1:0]     req_length,
   input  logic [brb_pkg::DATA_W-1:0]    req_write_data,
   output logic                          rsp_valid,
   output logic [brb_pkg::LEN_W-1:0]     rsp_done_count,
   output logic [brb_pkg::DATA_W-1:0]    rsp_read_data,
   output logic                          rsp_status,
   output logic [brb_pkg::LEN_W-1:0]     rsp_fill_level,
   output logic [brb_pkg::OFF_W-1:0]     rsp_span_offset,
   output logic [brb_pkg::LEN_W-1:0]     rsp_span_length,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [brb_pkg::LEN_W-1:0]     csr_data
);
   import brb_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CW    = (CNT_W > LEN_W) ? CNT_W : LEN_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WR   = 2'd1;
   localparam logic [1:0] ST_RD   = 2'd2;
   localparam logic [1:0] ST_RDL  = 2'd3;

   logic [7:0] mem [DEPTH];

   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  cap_ff, cap_in;
   logic [PTR_W-1:0]  wp_ff, wp_in;
   logic [PTR_W-1:0]  rp_ff, rp_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [PTR_W-1:0]  addr_ff, addr_in;
   logic [IDX_W-1:0]  cnt_ff, cnt_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [DATA_W-1:0] data_ff, data_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic              pend_ff, pend_in;
   logic [IDX_W-1:0]  pidx_ff, pidx_in;
   logic [7:0]        rd_byte_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [LEN_W-1:0]  done_ff, done_in;
   logic [DATA_W-1:0] rdata_ff, rdata_in;
   logic              status_ff, status_in;
   logic [LEN_W-1:0]  level_ff, level_in;
   logic [OFF_W-1:0]  soff_ff, soff_in;
   logic [LEN_W-1:0]  slen_ff, slen_in;

   logic              mem_we, mem_re;
   logic              accept, last;
   logic [PTR_W-1:0]  addr_step;
   logic [CNT_W-1:0]  avail_wr;
   logic [NUM_W-1:0]  len_sat, num_new;
   logic [CNT_W-1:0]  run;
   logic [CNT_W:0]    cons_sum;
   logic [CW-1:0]     cap_req;

   assign busy      = (state_ff != ST_IDLE);
   // an offered request wins over a capacity write
   assign csr_ready = !busy && !start;
   assign accept    = start && !busy;
   assign last      = ({1'b0, cnt_ff} == (num_ff - NUM_W'(1)));

   // next slot, wrapping at the programmed capacity
   assign addr_step = (CNT_W'(addr_ff) + CNT_W'(1) == cap_ff) ? '0 : addr_ff + PTR_W'(1);

   assign cap_req  = CW'(csr_data);
   assign avail_wr = cap_ff - fill_ff;
   assign run      = cap_ff - CNT_W'(rp_ff);
   assign cons_sum = (CNT_W + 1)'(rp_ff) + (CNT_W + 1)'(req_length);
   assign len_sat  = (req_length > LEN_W'(BURST_BYTES)) ? NUM_W'(BURST_BYTES)
                                                        : NUM_W'(req_length);

   always_comb begin
      num_new = len_sat;
      if (req_kind == KIND_WRITE) begin
         if (CW'(avail_wr) < CW'(len_sat)) begin
            num_new = NUM_W'(avail_wr);
         end
      end else begin
         if (CW'(fill_ff) < CW'(len_sat)) begin
            num_new = NUM_W'(fill_ff);
         end
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (pend_ff) begin
         acc_in[pidx_ff*8 +: 8] = rd_byte_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cap_in       = cap_ff;
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      fill_in      = fill_ff;
      addr_in      = addr_ff;
      cnt_in       = cnt_ff;
      num_in       = num_ff;
      kind_in      = kind_ff;
      data_in      = data_ff;
      pend_in      = 1'b0;
      pidx_in      = pidx_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      rsp_valid_in = 1'b0;
      done_in      = '0;
      rdata_in     = '0;
      status_in    = 1'b0;
      soff_in      = '0;
      slen_in      = '0;
      level_in     = LEN_W'(fill_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (csr_valid && csr_ready) begin
               if (cap_req < CW'(2)) begin
                  cap_in = CNT_W'(2);
               end else if (cap_req > CW'(DEPTH)) begin
                  cap_in = CNT_W'(DEPTH);
               end else begin
                  cap_in = CNT_W'(csr_data);
               end
               wp_in   = '0;
               rp_in   = '0;
               fill_in = '0;
            end else if (accept) begin
               addr_in = (req_kind == KIND_WRITE) ? wp_ff : rp_ff;
               cnt_in  = '0;
               num_in  = num_new;
               kind_in = req_kind;
               data_in = req_write_data;
               priority case (req_kind)
                  KIND_WRITE: begin
                     if (num_new != '0) begin
                        state_in = ST_WR;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  KIND_READ, KIND_PEEK: begin
                     if (num_new != '0) begin
                        state_in = ST_RD;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  KIND_CONSUME: begin
                     rsp_valid_in = 1'b1;
                     if (req_length != '0) begin
                        if (CW'(req_length) >= CW'(fill_ff)) begin
                           wp_in   = '0;
                           rp_in   = '0;
                           fill_in = '0;
                        end else begin
                           rp_in   = (cons_sum >= (CNT_W + 1)'(cap_ff))
                                   ? PTR_W'(cons_sum - (CNT_W + 1)'(cap_ff))
                                   : PTR_W'(cons_sum);
                           fill_in = fill_ff - CNT_W'(req_length);
                        end
                        level_in = LEN_W'(fill_in);
                     end
                  end
                  KIND_SPAN: begin
                     rsp_valid_in = 1'b1;
                     if (fill_ff == '0) begin
                        status_in = 1'b1;
                     end else begin
                        soff_in = OFF_W'(rp_ff);
                        slen_in = (fill_ff < run) ? LEN_W'(fill_ff) : LEN_W'(run);
                     end
                  end
                  KIND_CLEAR: begin
                     rsp_valid_in = 1'b1;
                     wp_in        = '0;
                     rp_in        = '0;
                     fill_in      = '0;
                     level_in     = '0;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_WR: begin
            mem_we  = 1'b1;
            data_in = data_ff >> 8;
            addr_in = addr_step;
            cnt_in  = cnt_ff + IDX_W'(1);
            if (last) begin
               wp_in        = addr_step;
               fill_in      = fill_ff + CNT_W'(num_ff);
               rsp_valid_in = 1'b1;
               done_in      = LEN_W'(num_ff);
               level_in     = LEN_W'(fill_in);
               state_in     = ST_IDLE;
            end
         end
         ST_RD: begin
            mem_re  = 1'b1;
            pend_in = 1'b1;
            pidx_in = cnt_ff;
            addr_in = addr_step;
            cnt_in  = cnt_ff + IDX_W'(1);
            if (last) begin
               state_in = ST_RDL;
            end
         end
         ST_RDL: begin
            // last byte lands from the store this cycle
            if (kind_ff == KIND_READ) begin
               rp_in   = addr_ff;
               fill_in = fill_ff - CNT_W'(num_ff);
            end
            rsp_valid_in = 1'b1;
            done_in      = LEN_W'(num_ff);
            rdata_in     = acc_in;
            level_in     = LEN_W'(fill_in);
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr_ff] <= data_ff[7:0];
      end
      if (mem_re) begin
         rd_byte_ff <= mem[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= CNT_W'(DEPTH);
         wp_ff        <= '0;
         rp_ff        <= '0;
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         fill_ff      <= fill_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      cnt_ff   <= cnt_in;
      num_ff   <= num_in;
      kind_ff  <= kind_in;
      data_ff  <= data_in;
      pidx_ff  <= pidx_in;
      acc_ff   <= accept ? '0 : acc_in;
      done_ff  <= done_in;
      rdata_ff <= rdata_in;
      status_ff <= status_in;
      level_ff <= level_in;
      soff_ff  <= soff_in;
      slen_ff  <= slen_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_done_count  = done_ff;
   assign rsp_read_data   = rdata_ff;
   assign rsp_status      = status_ff;
   assign rsp_fill_level  = level_ff;
   assign rsp_span_offset = soff_ff;
   assign rsp_span_length = slen_ff;

endmodule

FILE: design/brb_checker.sv
// port-level checks for the byte ring buffer, bound to byte_ring_buffer
// depends on brb_pkg
module brb_checker #(
   parameter int BURST_BYTES = brb_pkg::BURST_DEFAULT
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic                       rsp_valid,
   input logic [brb_pkg::LEN_W-1:0]  rsp_done_count,
   input logic [brb_pkg::DATA_W-1:0] rsp_read_data,
   input logic                       rsp_status,
   input logic [brb_pkg::LEN_W-1:0]  rsp_fill_level,
   input logic [brb_pkg::LEN_W-1:0]  rsp_span_length
);
   import brb_pkg::*;

   // a request either answers next cycle or keeps the block busy
   a_req_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> rsp_valid || busy)
      else $error("request neither answered nor in progress");

   // a burst ends with its result
   a_burst_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |-> rsp_valid)
      else $error("busy dropped without a result");

   a_burst_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_done_count <= LEN_W'(BURST_BYTES))
      else $error("done count beyond burst size");

   a_empty_span: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_fill_level == '0 && rsp_span_length == '0)
      else $error("empty span status with stored bytes");

   a_zero_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_count == '0 |-> rsp_read_data == '0)
      else $error("read data without bytes moved");

endmodule

bind byte_ring_buffer brb_checker #(.BURST_BYTES(BURST_BYTES)) u_brb_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_done_count  (rsp_done_count),
   .rsp_read_data   (rsp_read_data),
   .rsp_status      (rsp_status),
   .rsp_fill_level  (rsp_fill_level),
   .rsp_span_length (rsp_span_length)
);

FILE: sim/tb.sv
// testbench for byte_ring_buffer: directed and random requests checked against
// an in-bench ring buffer predictor, with random gaps on the request side
// depends on brb_pkg and the byte_ring_buffer rtl
module tb;
   import brb_pkg::*;

   localparam int CYCLE_LIMIT   = 1000;
   localparam int SETTLE_CYCLES = 12;
   localparam logic [KIND_W-1:0] KIND_SPARE6 = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SPARE7 = 3'd7;

   typedef struct packed {
      logic [LEN_W-1:0]  done_count;
      logic [DATA_W-1:0] read_data;
      logic              status;
      logic [LEN_W-1:0]  fill_level;
      logic [OFF_W-1:0]  span_offset;
      logic [LEN_W-1:0]  span_length;
   } ring_rsp_t;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [KIND_W-1:0] req_kind = '0;
   logic [LEN_W-1:0]  req_length = '0;
   logic [DATA_W-1:0] req_write_data = '0;
   logic              rsp_valid;
   logic [LEN_W-1:0]  rsp_done_count;
   logic [DATA_W-1:0] rsp_read_data;
   logic              rsp_status;
   logic [LEN_W-1:0]  rsp_fill_level;
   logic [OFF_W-1:0]  rsp_span_offset;
   logic [LEN_W-1:0]  rsp_span_length;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [LEN_W-1:0]  csr_data = '0;

   // predicted ring state
   logic [7:0] shadow_bytes [DEPTH_DEFAULT];
   int         shadow_wr;
   int         shadow_rd;
   int         shadow_cap;
   bit         shadow_full;

   ring_rsp_t  pending_rsp [$];
   int         mismatch_count = 0;
   int         quiet_cycles = 0;
   bit         no_gaps = 1'b0;

   byte_ring_buffer uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_length      (req_length),
      .req_write_data  (req_write_data),
      .rsp_valid       (rsp_valid),
      .rsp_done_count  (rsp_done_count),
      .rsp_read_data   (rsp_read_data),
      .rsp_status      (rsp_status),
      .rsp_fill_level  (rsp_fill_level),
      .rsp_span_offset (rsp_span_offset),
      .rsp_span_length (rsp_span_length),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [DATA_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic int shadow_fill();
      if (shadow_full) return shadow_cap;
      if (shadow_wr >= shadow_rd) return shadow_wr - shadow_rd;
      return shadow_cap - shadow_rd + shadow_wr;
   endfunction

   function automatic void shadow_empty();
      shadow_wr = 0;
      shadow_rd = 0;
      shadow_full = 1'b0;
   endfunction

   function automatic void shadow_set_capacity(logic [LEN_W-1:0] value);
      int c;
      c = int'(value);
      if (c < 2) c = 2;
      if (c > DEPTH_DEFAULT) c = DEPTH_DEFAULT;
      shadow_cap = c;
      shadow_empty();
   endfunction

   function automatic int burst_size(int asked, int avail);
      int n;
      n = asked;
      if (n > BURST_DEFAULT) n = BURST_DEFAULT;
      if (n > avail) n = avail;
      return n;
   endfunction

   function automatic ring_rsp_t ring_predict(logic [KIND_W-1:0] kind,
                                              logic [LEN_W-1:0] len,
                                              logic [DATA_W-1:0] wdata);
      ring_rsp_t r;
      int        fill;
      int        n;
      int        i;
      int        len_i;
      r = '0;
      fill = shadow_fill();
      len_i = int'(len);
      case (kind)
         KIND_WRITE: begin
            n = burst_size(len_i, shadow_cap - fill);
            for (i = 0; i < n; i++)
               shadow_bytes[(shadow_wr + i) % shadow_cap] = wdata[8*i +: 8];
            if (n > 0) begin
               shadow_wr = (shadow_wr + n) % shadow_cap;
               shadow_full = (shadow_wr == shadow_rd);
            end
            r.done_count = LEN_W'(n);
         end
         KIND_READ, KIND_PEEK: begin
            n = burst_size(len_i, fill);
            for (i = 0; i < n; i++)
               r.read_data[8*i +: 8] = shadow_bytes[(shadow_rd + i) % shadow_cap];
            if (kind == KIND_READ && n > 0) begin
               shadow_rd = (shadow_rd + n) % shadow_cap;
               shadow_full = 1'b0;
            end
            r.done_count = LEN_W'(n);
         end
         KIND_CONSUME: begin
            if (len_i != 0) begin
               // taking everything returns both pointers to slot zero
               if (len_i >= fill) begin
                  shadow_empty();
               end else begin
                  shadow_rd = (shadow_rd + len_i) % shadow_cap;
                  shadow_full = 1'b0;
               end
            end
         end
         KIND_SPAN: begin
            if (fill == 0) begin
               r.status = 1'b1;
            end else begin
               r.span_offset = OFF_W'(shadow_rd);
               r.span_length = LEN_W'((fill < shadow_cap - shadow_rd) ? fill
                                                                       : shadow_cap - shadow_rd);
            end
         end
         KIND_CLEAR: begin
            shadow_empty();
         end
         default: begin
         end
      endcase
      r.fill_level = LEN_W'(shadow_fill());
      return r;
   endfunction

   task automatic send_request(input logic [KIND_W-1:0] kind, input logic [LEN_W-1:0] len,
                               input logic [DATA_W-1:0] wdata);
      if (!no_gaps && $urandom_range(0, 99) < 11) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start <= 1'b1;
      req_kind <= kind;
      req_length <= len;
      req_write_data <= wdata;
      do @(posedge clock); while (busy);
      pending_rsp.push_back(ring_predict(kind, len, wdata));
   endtask

   task automatic wait_for_idle();
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_capacity(input logic [LEN_W-1:0] value);
      wait_for_idle();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      shadow_set_capacity(value);
   endtask

   function automatic logic [KIND_W-1:0] pick_kind(int write_pct, bit fill_mode);
      int r;
      if ($urandom_range(0, 99) < write_pct) return KIND_WRITE;
      r = $urandom_range(0, 99);
      if (fill_mode) begin
         // no clear or consume while filling up
         if (r < 40) return KIND_READ;
         if (r < 70) return KIND_PEEK;
         return KIND_SPAN;
      end
      if (r < 30) return KIND_READ;
      if (r < 50) return KIND_PEEK;
      if (r < 68) return KIND_CONSUME;
      if (r < 88) return KIND_SPAN;
      if (r < 95) return KIND_CLEAR;
      if (r < 97) return KIND_SPARE6;
      return KIND_SPARE7;
   endfunction

   function automatic logic [LEN_W-1:0] pick_length(logic [KIND_W-1:0] kind, bit fill_mode);
      int r;
      r = $urandom_range(0, 99);
      if (fill_mode && kind == KIND_WRITE) begin
         if (r < 80) return LEN_W'(8);
         return LEN_W'($urandom_range(9, 4096));
      end
      if (kind == KIND_CONSUME) begin
         if (r < 60) return LEN_W'($urandom_range(1, 8));
         if (r < 85) return LEN_W'($urandom_range(0, 40));
         return LEN_W'($urandom_range(0, 4096));
      end
      if (r < 75) return LEN_W'($urandom_range(1, 8));
      if (r < 80) return '0;
      return LEN_W'($urandom_range(9, 4096));
   endfunction

   task automatic random_phase(input int cap, input int items, input int write_pct,
                               input bit fill_mode);
      logic [KIND_W-1:0] kind;
      set_capacity(LEN_W'(cap));
      repeat (items) begin
         kind = pick_kind(write_pct, fill_mode);
         send_request(kind, pick_length(kind, fill_mode), rand64());
      end
   endtask

   task automatic test_empty_buffer();
      send_request(KIND_READ, 8, rand64());
      send_request(KIND_PEEK, 8, rand64());
      send_request(KIND_SPAN, 0, rand64());
      send_request(KIND_WRITE, 0, '1);
      send_request(KIND_CONSUME, 0, '0);
      send_request(KIND_SPARE6, 5, rand64());
      send_request(KIND_SPARE7, 4096, '1);
   endtask

   task automatic test_basic_ops();
      send_request(KIND_WRITE, 8, '1);
      send_request(KIND_WRITE, 4096, rand64());
      send_request(KIND_PEEK, 3, '0);
      send_request(KIND_READ, 4096, '0);
      send_request(KIND_READ, 0, '0);
      send_request(KIND_SPAN, 0, '0);
      send_request(KIND_CONSUME, 1, '0);
      send_request(KIND_SPAN, 0, '0);
      send_request(KIND_CONSUME, 4096, '0);
      send_request(KIND_WRITE, 5, rand64());
      send_request(KIND_CLEAR, 0, '0);
      send_request(KIND_SPAN, 0, '0);
   endtask

   task automatic test_small_capacity();
      // below the minimum acts as two slots
      set_capacity(13'd0);
      send_request(KIND_WRITE, 8, rand64());
      send_request(KIND_WRITE, 1, rand64());
      send_request(KIND_SPAN, 0, '0);
      send_request(KIND_READ, 1, '0);
      send_request(KIND_WRITE, 1, rand64());
      send_request(KIND_SPAN, 0, '0);
      send_request(KIND_PEEK, 8, '0);
      send_request(KIND_READ, 8, '0);
      set_capacity(13'd1);
      send_request(KIND_WRITE, 8, '0);
      // above the store size acts as the full store
      set_capacity(13'h1fff);
      send_request(KIND_WRITE, 8, '1);
      send_request(KIND_SPAN, 0, '0);
   endtask

   task automatic test_random();
      random_phase(3, 56, 40, 1'b0);
      random_phase($urandom_range(4, 16), 56, 45, 1'b0);
      no_gaps = 1'b1;
      random_phase($urandom_range(17, 64), 112, 50, 1'b0);
      no_gaps = 1'b0;
      random_phase(1, 56, 40, 1'b0);
      random_phase(2, 56, 40, 1'b0);
      random_phase(DEPTH_DEFAULT, 650, 95, 1'b1);
      random_phase($urandom_range(4097, 8191), 56, 50, 1'b0);
      random_phase($urandom_range(100, 400), 56, 60, 1'b0);
      random_phase($urandom_range(4, 12), 56, 45, 1'b0);
   endtask

   // response checker
   always @(posedge clock) begin
      ring_rsp_t got;
      ring_rsp_t want;
      if (!reset && rsp_valid === 1'b1) begin
         got = {rsp_done_count, rsp_read_data, rsp_status, rsp_fill_level,
                rsp_span_offset, rsp_span_length};
         if (pending_rsp.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected response: done %0d data %h status %0d fill %0d span %0d/%0d",
                        got.done_count, got.read_data, got.status, got.fill_level,
                        got.span_offset, got.span_length);
            mismatch_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (got !== want) begin
               if (mismatch_count < 10) begin
                  $display("mismatch: expected done %0d data %h status %0d fill %0d span %0d/%0d",
                           want.done_count, want.read_data, want.status, want.fill_level,
                           want.span_offset, want.span_length);
                  $display("          actual   done %0d data %h status %0d fill %0d span %0d/%0d",
                           got.done_count, got.read_data, got.status, got.fill_level,
                           got.span_offset, got.span_length);
               end
               mismatch_count++;
            end
         end
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid === 1'b1 || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      for (int i = 0; i < DEPTH_DEFAULT; i++) shadow_bytes[i] = 8'h00;
      shadow_cap = DEPTH_DEFAULT;
      shadow_empty();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_empty_buffer();
      test_basic_ops();
      test_small_capacity();
      test_random();
      wait_for_idle();
      if (mismatch_count == 0 && pending_rsp.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: sim.f
design/brb_pkg.sv
design/byte_ring_buffer.sv
design/brb_checker.sv
sim/tb.sv
